### hw/rtl/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types and constants for the triangle grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

   localparam int GRID_SIZE_DEF  = 128;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   localparam int COORD_W     = 15;
   localparam int SAMPLE_W    = 32;
   localparam int NUM_BANKS   = 4;
   localparam int BANK_W      = 2;
   // widest bank address and fraction over the whole parameter range
   localparam int BADDR_MAX_W = 18;
   localparam int FRAC_MAX_W  = 17;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef logic [BANK_W-1:0] bank_type;

   // bank index is {row parity, column parity}
   localparam bank_type ROW_FLIP  = 2'b10;
   localparam bank_type COL_FLIP  = 2'b01;
   localparam bank_type DIAG_FLIP = 2'b11;

   typedef struct packed {
      func_type                    func;
      logic [COORD_W-1:0]          k1_grid;
      logic [COORD_W-1:0]          k2_grid;
      logic signed [SAMPLE_W-1:0]  table_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  value;
      logic                        clamped;
   } rsp_type;

   // one classified request, front to back
   typedef struct packed {
      func_type                                 func;
      bank_type                                 bank;       // write bank or corner bank
      logic [NUM_BANKS-1:0][BADDR_MAX_W-1:0]    addr;
      logic signed [SAMPLE_W-1:0]               wdata;
      logic                                     side_first;
      logic [FRAC_MAX_W-1:0]                    dbig;
      logic [FRAC_MAX_W-1:0]                    dsmall;
      logic                                     clamped;
   } cmd_type;

endpackage

### hw/rtl/tgi_front.sv
// ----------------------------------------------------------------------------
// tgi_front
// Accepts requests, tracks the load position and turns each request into a
// bank-addressed command for the back end.
// ----------------------------------------------------------------------------
module tgi_front import tgi_pkg::*; #(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    queue_full,
   output logic    push,
   output cmd_type push_cmd
);

   localparam int CELL_W     = $clog2(GRID_SIZE);
   localparam int HALF       = (GRID_SIZE + 1) / 2;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(GRID_SIZE - 2);
   localparam logic [CELL_W-1:0] LAST_IDX  = CELL_W'(GRID_SIZE - 1);
   localparam logic [FRAC_MAX_W-1:0] FRAC_ONE  = FRAC_MAX_W'(1) << FRAC_BITS;
   localparam logic [FRAC_MAX_W-1:0] FRAC_MASK = FRAC_ONE - FRAC_MAX_W'(1);

   typedef struct packed {
      logic                  clamp;
      logic [CELL_W-1:0]     idx;
      logic [FRAC_MAX_W-1:0] frac;
   } coord_type;

   function automatic coord_type split_coord(input logic [COORD_W-1:0] k);
      coord_type          c;
      logic [COORD_W-1:0] ip;
      ip      = k >> FRAC_BITS;
      c.clamp = ip > COORD_W'(GRID_SIZE - 2);
      c.idx   = c.clamp ? LAST_CELL : ip[CELL_W-1:0];
      c.frac  = c.clamp ? FRAC_ONE : (FRAC_MAX_W'(k) & FRAC_MASK);
      return c;
   endfunction

   // row-major position split across four parity banks
   function automatic logic [BADDR_MAX_W-1:0] bank_addr(input logic [CELL_W-1:0] row,
                                                        input logic [CELL_W-1:0] col);
      logic [BADDR_W-1:0] a;
      a = BADDR_W'(row >> 1) * BADDR_W'(HALF) + BADDR_W'(col >> 1);
      return BADDR_MAX_W'(a);
   endfunction

   logic [CELL_W-1:0] load_row_ff, load_row_in;
   logic [CELL_W-1:0] load_col_ff, load_col_in;
   coord_type         c1, c2;
   logic [CELL_W-1:0] qrow [NUM_BANKS];
   logic [CELL_W-1:0] qcol [NUM_BANKS];
   logic              is_load;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign is_load   = (req_payload.func == FUNC_LOAD);
   assign c1        = split_coord(req_payload.k1_grid);
   assign c2        = split_coord(req_payload.k2_grid);

   always_comb begin
      push_cmd            = '0;
      push_cmd.func       = req_payload.func;
      push_cmd.wdata      = req_payload.table_value;
      push_cmd.clamped    = c1.clamp || c2.clamp;
      push_cmd.side_first = c1.frac > c2.frac;
      push_cmd.dbig       = push_cmd.side_first ? c1.frac : c2.frac;
      push_cmd.dsmall     = push_cmd.side_first ? c2.frac : c1.frac;
      // each bank holds exactly one of the four cell corners
      for (int b = 0; b < NUM_BANKS; b++) begin
         qrow[b] = (b[1] == c1.idx[0]) ? c1.idx : c1.idx + 1'b1;
         qcol[b] = (b[0] == c2.idx[0]) ? c2.idx : c2.idx + 1'b1;
         push_cmd.addr[b] = is_load ? bank_addr(load_row_ff, load_col_ff)
                                    : bank_addr(qrow[b], qcol[b]);
      end
      push_cmd.bank = is_load ? {load_row_ff[0], load_col_ff[0]}
                              : {c1.idx[0], c2.idx[0]};
   end

   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      if (push && is_load) begin
         if (load_col_ff == LAST_IDX) begin
            load_col_in = '0;
            load_row_in = (load_row_ff == LAST_IDX) ? '0 : load_row_ff + 1'b1;
         end else begin
            load_col_in = load_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
      end else begin
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
      end
   end

endmodule

### hw/rtl/tgi_queue.sv
// ----------------------------------------------------------------------------
// tgi_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module tgi_queue import tgi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count past depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

### hw/rtl/tgi_back.sv
// ----------------------------------------------------------------------------
// tgi_back
// Four parity banks of samples and the plane evaluation pipeline.
// ----------------------------------------------------------------------------
module tgi_back import tgi_pkg::*; #(
   parameter int GRID_SIZE  = GRID_SIZE_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int HALF       = (GRID_SIZE + 1) / 2;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int D_W        = FRAC_BITS + 1;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int ACC_W      = FRAC_BITS + SAMPLE_W + 3;
   localparam int Q_W        = ACC_W - FRAC_BITS;
   localparam int CMP_W      = ((VALUE_BITS > Q_W) ? VALUE_BITS : Q_W) + 1;
   localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [CMP_W-1:0] SAT_HI = (CMP_W'(1) << (VALUE_BITS - 1)) - CMP_W'(1);
   localparam logic signed [CMP_W-1:0] SAT_LO = ~SAT_HI;

   logic                       adv;
   logic                       bank_re;
   logic [NUM_BANKS-1:0]       bank_we;
   logic signed [SAMPLE_W-1:0] rd_ff [NUM_BANKS];

   // stage 1: bank read
   logic                  s1_valid_ff;
   bank_type              s1_bank_ff;
   logic                  s1_side_first_ff;
   logic [D_W-1:0]        s1_dbig_ff, s1_dsmall_ff;
   logic                  s1_clamped_ff;
   // stage 2: corner pick and edge differences
   logic                     s2_valid_ff;
   logic signed [SAMPLE_W-1:0] z1, z2, z3;
   logic signed [DIFF_W-1:0] e_in, g_in, e_ff, g_ff;
   logic signed [SAMPLE_W-1:0] s2_z1_ff;
   logic [D_W-1:0]           s2_dbig_ff, s2_dsmall_ff;
   logic                     s2_clamped_ff;
   // stage 3: products
   logic                    s3_valid_ff;
   logic signed [ACC_W-1:0] p1_in, p2_in, base_in;
   logic signed [ACC_W-1:0] p1_ff, p2_ff, s3_base_ff;
   logic                    s3_clamped_ff;
   // stage 4: product sum
   logic                    s4_valid_ff;
   logic signed [ACC_W-1:0] t_ff, s4_base_ff;
   logic                    s4_clamped_ff;
   // stage 5: rounded quotient
   logic                    s5_valid_ff;
   logic signed [ACC_W-1:0] n_in;
   logic signed [Q_W-1:0]   q_ff;
   logic                    s5_clamped_ff;
   // output register
   logic                    out_valid_ff;
   rsp_type                 out_ff, out_in;
   logic signed [CMP_W-1:0] qx, sat;

   assign adv     = !out_valid_ff || !rsp_stall;
   assign pop     = head_valid && adv;
   assign bank_re = pop && (head_cmd.func == FUNC_QUERY);

   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_we[b] = pop && (head_cmd.func == FUNC_LOAD) && (head_cmd.bank == BANK_W'(b));
      end
   end

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic signed [SAMPLE_W-1:0] mem [BANK_DEPTH];
      always_ff @(posedge clock) begin
         if (bank_we[g]) begin
            mem[head_cmd.addr[g][BADDR_W-1:0]] <= head_cmd.wdata;
         end
         if (bank_re) begin
            rd_ff[g] <= mem[head_cmd.addr[g][BADDR_W-1:0]];
         end
      end
   end

   // side sample sits in the row-flipped bank when the first fraction wins
   always_comb begin
      z1 = rd_ff[s1_bank_ff];
      z2 = rd_ff[s1_bank_ff ^ DIAG_FLIP];
      z3 = rd_ff[s1_side_first_ff ? (s1_bank_ff ^ ROW_FLIP) : (s1_bank_ff ^ COL_FLIP)];
      e_in = DIFF_W'(z3) - DIFF_W'(z1);
      g_in = DIFF_W'(z2) - DIFF_W'(z3);
   end

   always_comb begin
      p1_in   = ACC_W'(e_ff) * ACC_W'($signed({1'b0, s2_dbig_ff}));
      p2_in   = ACC_W'(g_ff) * ACC_W'($signed({1'b0, s2_dsmall_ff}));
      base_in = (ACC_W'(s2_z1_ff) <<< FRAC_BITS) + ROUND;
      n_in    = t_ff + s4_base_ff;
   end

   always_comb begin
      qx = CMP_W'(q_ff);
      if (qx > SAT_HI) begin
         sat = SAT_HI;
      end else if (qx < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = qx;
      end
      out_in.value   = sat[SAMPLE_W-1:0];
      out_in.clamped = s5_clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= bank_re;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bank_ff       <= head_cmd.bank;
         s1_side_first_ff <= head_cmd.side_first;
         s1_dbig_ff       <= head_cmd.dbig[D_W-1:0];
         s1_dsmall_ff     <= head_cmd.dsmall[D_W-1:0];
         s1_clamped_ff    <= head_cmd.clamped;

         e_ff          <= e_in;
         g_ff          <= g_in;
         s2_z1_ff      <= z1;
         s2_dbig_ff    <= s1_dbig_ff;
         s2_dsmall_ff  <= s1_dsmall_ff;
         s2_clamped_ff <= s1_clamped_ff;

         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         s3_base_ff    <= base_in;
         s3_clamped_ff <= s2_clamped_ff;

         t_ff          <= p1_ff + p2_ff;
         s4_base_ff    <= s3_base_ff;
         s4_clamped_ff <= s3_clamped_ff;

         q_ff          <= Q_W'(n_in >>> FRAC_BITS);
         s5_clamped_ff <= s4_clamped_ff;

         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.func == FUNC_QUERY) |=> s1_valid_ff)
      else $error("popped query lost before stage 1");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.func == FUNC_LOAD) |=> !s1_valid_ff)
      else $error("load entered evaluation pipeline");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> $stable(s5_valid_ff) && !$past(pop))
      else $error("pipeline moved while output held");

endmodule

### hw/rtl/triangle_grid_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_grid_interpolator
// Square sample grid with plane interpolation over the triangle of a cell.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall/req_payload. A load request
// (func = load) writes table_value at the next row-major position and gives
// no response; the position wraps after the last grid entry. A query request
// gives two coordinates with FRAC_BITS fraction bits and yields one response
// on rsp_valid/rsp_stall/rsp_payload: the saturated plane value and a flag
// that a coordinate was clamped to the last cell.
// The grid is split into four banks by row and column parity, so the corner,
// diagonal and side samples of a query are read in the same cycle. One request
// is taken per cycle while the queue is not full; a query passes the queue, then
// the bank read, select, multiply, add, round and saturate registers, before its
// response is valid. Reset clears the load position, the command queue and all
// pipeline valids; grid contents are undefined until loaded. While rsp_stall is
// high and a response is waiting, the evaluation pipeline holds; the four-entry
// queue keeps accepting until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module triangle_grid_interpolator import tgi_pkg::*; #(
   parameter int GRID_SIZE  = GRID_SIZE_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    push, queue_full, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   tgi_front #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tgi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   tgi_back #(
      .GRID_SIZE  (GRID_SIZE),
      .FRAC_BITS  (FRAC_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### sim/triangle_grid_interpolator_test.sv
// ----------------------------------------------------------------------------
// triangle_grid_interpolator_test
// Self-checking bench for the triangle grid interpolator.
// ----------------------------------------------------------------------------
// The whole grid is loaded first, so every later query reads written samples.
// A directed set of queries and loads follows. It covers clamped and unclamped
// coordinates, equal fractions, extreme samples and the load position wrapping
// back to the first entry. Four chunks of random requests come after that.
// A behavioral copy of the grid predicts each query response when the request
// is accepted. Responses are checked in order against those predictions. Both
// sides insert random idle gaps. One long response stall fills the block, and
// one chunk runs with no idling at all.
// ----------------------------------------------------------------------------
module triangle_grid_interpolator_test;
   import tgi_pkg::*;

   localparam int GRID_SIZE      = GRID_SIZE_DEF;
   localparam int FRAC_BITS      = FRAC_BITS_DEF;
   localparam int VALUE_BITS     = VALUE_BITS_DEF;
   localparam int GRID_CELLS     = GRID_SIZE * GRID_SIZE;
   localparam int FRAC_ONE       = 1 << FRAC_BITS;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int LONG_HOLD      = 150;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // bench-side copy of the grid and load pointer
   logic signed [SAMPLE_W-1:0] grid_samples [GRID_CELLS];
   int unsigned load_index = 0;

   req_type pending_reqs [$];
   rsp_type expected_results [$];

   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_orders = 0;
   int unsigned hold_served = 0;
   bit          quiet_mode = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;
   int unsigned idle_cycles = 0;

   triangle_grid_interpolator #(
      .GRID_SIZE  (GRID_SIZE),
      .FRAC_BITS  (FRAC_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit split_coordinate(input logic [COORD_W-1:0] raw,
                                           output int unsigned cell_idx,
                                           output longint frac);
      int unsigned whole;
      whole = int'(raw) >> FRAC_BITS;
      if (whole > GRID_SIZE - 2) begin
         // past the last full cell: pin to the far edge of the last cell
         cell_idx = GRID_SIZE - 2;
         frac     = FRAC_ONE;
         return 1'b1;
      end
      cell_idx = whole;
      frac     = int'(raw) & (FRAC_ONE - 1);
      return 1'b0;
   endfunction

   function automatic longint sample_at(input int unsigned row, input int unsigned col);
      return longint'(grid_samples[row * GRID_SIZE + col]);
   endfunction

   function automatic rsp_type plane_value(input req_type request);
      int unsigned row, col;
      longint      d1, d2, z_corner, z_diag, z_side, acc, lim_hi, lim_lo;
      bit          clip1, clip2;
      rsp_type     res;
      clip1    = split_coordinate(request.k1_grid, row, d1);
      clip2    = split_coordinate(request.k2_grid, col, d2);
      z_corner = sample_at(row, col);
      z_diag   = sample_at(row + 1, col + 1);
      if (d1 > d2) begin
         z_side = sample_at(row + 1, col);
         acc    = z_corner * FRAC_ONE + (z_side - z_corner) * d1 + (z_diag - z_side) * d2;
      end else begin
         // equal fractions take this triangle too
         z_side = sample_at(row, col + 1);
         acc    = z_corner * FRAC_ONE + (z_diag - z_side) * d1 + (z_side - z_corner) * d2;
      end
      acc    = (acc + FRAC_ONE / 2) >>> FRAC_BITS;
      lim_hi = (longint'(1) << (VALUE_BITS - 1)) - 1;
      lim_lo = -lim_hi - 1;
      if (acc > lim_hi)
         acc = lim_hi;
      else if (acc < lim_lo)
         acc = lim_lo;
      res.value   = acc[SAMPLE_W-1:0];
      res.clamped = clip1 | clip2;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [COORD_W-1:0] grid_coord(input int unsigned whole,
                                                     input int unsigned frac);
      return COORD_W'((whole << FRAC_BITS) | frac);
   endfunction

   function automatic req_type query_request(input logic [COORD_W-1:0] k1,
                                             input logic [COORD_W-1:0] k2);
      req_type r;
      r.func        = FUNC_QUERY;
      r.k1_grid     = k1;
      r.k2_grid     = k2;
      r.table_value = $urandom;
      return r;
   endfunction

   function automatic req_type load_request(input logic signed [SAMPLE_W-1:0] word);
      req_type r;
      r.func        = FUNC_LOAD;
      r.k1_grid     = COORD_W'($urandom);
      r.k2_grid     = COORD_W'($urandom);
      r.table_value = word;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 5))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return int'($urandom_range(0, 2000)) - 1000;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0: return grid_coord(GRID_SIZE - 1, $urandom_range(0, FRAC_ONE - 1));
         1: return grid_coord(GRID_SIZE - 2, $urandom_range(0, FRAC_ONE - 1));
         2: return grid_coord($urandom_range(0, GRID_SIZE - 1), 0);
         3: return grid_coord($urandom_range(0, 1), $urandom_range(0, FRAC_ONE - 1));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      logic [COORD_W-1:0] k1, k2;
      if ($urandom_range(0, 3) == 0)
         return load_request(random_sample());
      k1 = random_coord();
      k2 = random_coord();
      if ($urandom_range(0, 7) == 0)
         k2[FRAC_BITS-1:0] = k1[FRAC_BITS-1:0];
      return query_request(k1, k2);
   endfunction

   function automatic int unsigned idle_length();
      int unsigned roll;
      if (quiet_mode)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_payload <= pending_reqs.pop_front();
            req_valid   <= 1'b1;
            gap_left    <= idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response-side backpressure, with an on-demand long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_orders) begin
         hold_served <= hold_orders;
         stall_left  <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0)
            stall_left <= idle_length();
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : score
      rsp_type want;
      req_taken <= req_valid && !req_stall;
      if (reset) begin
         load_index = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_payload.func == FUNC_LOAD) begin
               grid_samples[load_index] = req_payload.table_value;
               load_index = (load_index + 1 == GRID_CELLS) ? 0 : load_index + 1;
            end else begin
               expected_results.push_back(plane_value(req_payload));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("response %0d unexpected: value %0d clamped %0b", result_count,
                           rsp_payload.value, rsp_payload.clamped);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.value !== want.value || rsp_payload.clamped !== want.clamped)
               begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("response %0d: expected value %0d clamped %0b, got %0d %0b",
                              result_count, want.value, want.clamped,
                              rsp_payload.value, rsp_payload.clamped);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("triangle_grid_interpolator verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int unsigned row, col, idx, chunk, n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole grid; a 2x2 block of extremes sits at cell (10,10)
      for (idx = 0; idx < GRID_CELLS; idx++) begin
         row = idx / GRID_SIZE;
         col = idx % GRID_SIZE;
         if ((row == 10 || row == 11) && (col == 10 || col == 11))
            pending_reqs.push_back(load_request(((row + col) % 2 == 0) ? SAMPLE_MAX
                                                                       : SAMPLE_MIN));
         else
            pending_reqs.push_back(load_request(random_sample()));
      end

      pending_reqs.push_back(query_request(grid_coord(0, 0), grid_coord(0, 0)));
      pending_reqs.push_back(query_request(15'h7FFF, 15'h7FFF));
      pending_reqs.push_back(query_request(15'h7FFF, grid_coord(0, 0)));
      pending_reqs.push_back(query_request(grid_coord(0, 0), 15'h7FFF));
      pending_reqs.push_back(query_request(grid_coord(GRID_SIZE - 2, FRAC_ONE - 1),
                                           grid_coord(GRID_SIZE - 2, FRAC_ONE - 1)));
      pending_reqs.push_back(query_request(grid_coord(GRID_SIZE - 1, 0), grid_coord(3, 1)));
      pending_reqs.push_back(query_request(grid_coord(10, 200), grid_coord(10, 50)));
      pending_reqs.push_back(query_request(grid_coord(10, 50), grid_coord(10, 200)));
      pending_reqs.push_back(query_request(grid_coord(10, 128), grid_coord(10, 128)));
      pending_reqs.push_back(query_request(grid_coord(10, FRAC_ONE - 1), grid_coord(10, 1)));
      pending_reqs.push_back(query_request(grid_coord(5, 'h55), grid_coord(7, 'hAA)));
      pending_reqs.push_back(query_request(15'h2AAA, 15'h5555));
      pending_reqs.push_back(query_request(15'h5555, 15'h2AAA));
      // load pointer has wrapped: these overwrite the first row
      pending_reqs.push_back(load_request(SAMPLE_MAX));
      pending_reqs.push_back(load_request(SAMPLE_MIN));
      pending_reqs.push_back(load_request(32'sd12345));
      pending_reqs.push_back(query_request(grid_coord(0, 64), grid_coord(0, 128)));
      pending_reqs.push_back(query_request(grid_coord(0, 128), grid_coord(0, 64)));
      wait_for_drain();

      for (chunk = 0; chunk < 4; chunk++) begin
         while (pending_reqs.size() != 0)
            @(posedge clock);
         quiet_mode = (chunk == 2);
         for (n = 0; n < RANDOM_ITEMS / 4; n++)
            pending_reqs.push_back(random_request());
         if (chunk == 1)
            hold_orders++;
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("triangle_grid_interpolator verification clean");
      else
         $display("triangle_grid_interpolator verification failed");
      $finish;
   end

endmodule
